FILE: rtl/core/smf_pkg.sv
// smf_pkg: shared types for the sliding median filter.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps

package smf_pkg;

	// Per-beat control broadcast to every cell of the sorted chain.
	typedef struct packed {
		logic step;   // an input beat is taken this cycle
		logic flush;  // that beat closes the row: empty the window after use
	} smf_ctl_t;

endpackage : smf_pkg

FILE: rtl/core/smf_if.sv
// smf_in_if / smf_out_if: valid/ready stream interfaces for samples and medians.
// Depend on nothing; width comes from the instantiating level.
`timescale 1ns / 1ps

interface smf_in_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   last_in_row;

	modport source (output valid, output sample, output last_in_row, input ready);
	modport sink (input valid, input sample, input last_in_row, output ready);
endinterface : smf_in_if

interface smf_out_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface : smf_out_if

FILE: rtl/core/smf_cell.sv
// smf_cell: one slot of the sorted window (value, age, valid).
// Depends on smf_pkg; talks only to its two neighbors.
`timescale 1ns / 1ps

module smf_cell
	import smf_pkg::*;
#(
	parameter int DATA_W   = 12,
	parameter int AGE_W    = 3,
	parameter int LAST_AGE = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  smf_ctl_t          ctl,
	input  logic [DATA_W-1:0] x,
	// raw state of the next higher cell
	input  logic [DATA_W-1:0] up_val,
	input  logic [AGE_W-1:0]  up_age,
	input  logic              up_valid,
	input  logic              up_gt,
	// compacted state of the next lower cell
	input  logic [DATA_W-1:0] dn_val,
	input  logic [AGE_W-1:0]  dn_age,
	input  logic              dn_valid,
	input  logic              dn_ins,
	// removal has happened at or below this point
	input  logic              sh_in,
	output logic              sh_out,
	// own raw state
	output logic [DATA_W-1:0] val,
	output logic [AGE_W-1:0]  age,
	output logic              valid,
	output logic              gt,
	output logic              rm,
	// own compacted state
	output logic [DATA_W-1:0] cval,
	output logic [AGE_W-1:0]  cage,
	output logic              cvalid,
	output logic              cins,
	// value this slot takes on a step
	output logic [DATA_W-1:0] nxt_val
);

	localparam logic [AGE_W-1:0] LAST_A = AGE_W'(LAST_AGE);

	logic [DATA_W-1:0] val_q;
	logic [AGE_W-1:0]  age_q;
	logic              valid_q;
	logic [AGE_W-1:0]  nxt_age;
	logic              nxt_valid;

	assign val   = val_q;
	assign age   = age_q;
	assign valid = valid_q;

	// empty slots sort above everything
	assign gt     = !valid_q || (val_q > x);
	assign rm     = valid_q && (age_q == LAST_A);
	assign sh_out = sh_in || rm;

	// state once the oldest entry is squeezed out
	assign cval   = sh_out ? up_val   : val_q;
	assign cage   = sh_out ? up_age   : age_q;
	assign cvalid = sh_out ? up_valid : valid_q;
	assign cins   = sh_out ? up_gt    : gt;

	always_comb begin
		if (cins && dn_ins) begin
			nxt_val   = dn_val;
			nxt_age   = dn_age + AGE_W'(1);
			nxt_valid = dn_valid;
		end else if (cins) begin
			nxt_val   = x;
			nxt_age   = '0;
			nxt_valid = 1'b1;
		end else begin
			nxt_val   = cval;
			nxt_age   = cage + AGE_W'(1);
			nxt_valid = cvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.step) begin
			valid_q <= nxt_valid && !ctl.flush;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

endmodule : smf_cell

FILE: rtl/core/sliding_median_filter_unit.sv
// sliding_median_filter_unit: running median over the last WINDOW_TAPS samples of a row.
// Depends on smf_pkg, smf_in_if / smf_out_if and smf_cell.
//
//   port       | dir  | beat payload          | note
//   -----------+------+-----------------------+------------------------------------
//   sample_ch  | sink | sample, last_in_row   | one sample per beat
//   median_ch  | src  | median                | one beat per sample once window full
//
// Cycles: one sample per clock while the output is not held back; the median is
//   registered and leaves in the cycle after its sample is taken. The rate is set by the
//   sorted cell chain, which removes the oldest entry and inserts the new one in a single update.
// Reset: arst_n clears the fill count, the cell valid bits and the output valid.
// Stalls: the output register holds a median until taken; a new sample is taken in
//   the same cycle the held median leaves, so a ready sink sees no bubbles.
`timescale 1ns / 1ps

module sliding_median_filter_unit
	import smf_pkg::*;
#(
	parameter int WINDOW_TAPS = 7,
	parameter int SAMPLE_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	smf_in_if.sink     sample_ch,
	smf_out_if.source  median_ch
);

	localparam int N      = WINDOW_TAPS;
	localparam int AGE_W  = $clog2(N);
	localparam int CNT_W  = $clog2(N + 1);
	localparam int MID    = N / 2;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(N);

	// Sorted window: cell 0 holds the smallest value, empty cells sit on top.
	// Every entry carries its age; the one aged N-1 is the oldest and leaves
	// when the next sample comes in.
	logic [SAMPLE_BITS-1:0] val_w  [N];
	logic [AGE_W-1:0]       age_w  [N];
	logic [N-1:0]           valid_w;
	logic [N-1:0]           gt_w;
	logic [N-1:0]           rm_w;
	logic [SAMPLE_BITS-1:0] cval_w [N];
	logic [AGE_W-1:0]       cage_w [N];
	logic [N-1:0]           cvalid_w;
	logic [N-1:0]           cins_w;
	logic [N-1:0]           sh_w;
	logic [SAMPLE_BITS-1:0] nxt_w  [N];

	smf_ctl_t               ctl;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_nxt;
	logic                   emit;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] median_q;

	// Taking a sample is allowed whenever the output slot is free or draining.
	assign sample_ch.ready = !out_valid_q || median_ch.ready;
	assign ctl = '{
		step:  sample_ch.valid && sample_ch.ready,
		flush: sample_ch.last_in_row
	};

	// Fill count saturates at a full window; a median is due once it is full.
	assign count_nxt = (count_q == FULL) ? FULL : count_q + CNT_W'(1);
	assign emit      = (count_nxt == FULL);

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			logic [SAMPLE_BITS-1:0] up_val;
			logic [AGE_W-1:0]       up_age;
			logic                   up_valid;
			logic                   up_gt;
			logic [SAMPLE_BITS-1:0] dn_val;
			logic [AGE_W-1:0]       dn_age;
			logic                   dn_valid;
			logic                   dn_ins;
			logic                   sh_in;

			if (gi == N - 1) begin : g_top
				// above the chain: an empty slot
				assign up_val   = '0;
				assign up_age   = '0;
				assign up_valid = 1'b0;
				assign up_gt    = 1'b1;
			end else begin : g_mid_up
				assign up_val   = val_w[gi+1];
				assign up_age   = age_w[gi+1];
				assign up_valid = valid_w[gi+1];
				assign up_gt    = gt_w[gi+1];
			end

			if (gi == 0) begin : g_bot
				// below the chain: never above the new sample
				assign dn_val   = '0;
				assign dn_age   = '0;
				assign dn_valid = 1'b0;
				assign dn_ins   = 1'b0;
				assign sh_in    = 1'b0;
			end else begin : g_mid_dn
				assign dn_val   = cval_w[gi-1];
				assign dn_age   = cage_w[gi-1];
				assign dn_valid = cvalid_w[gi-1];
				assign dn_ins   = cins_w[gi-1];
				assign sh_in    = sh_w[gi-1];
			end

			smf_cell #(
				.DATA_W   (SAMPLE_BITS),
				.AGE_W    (AGE_W),
				.LAST_AGE (N - 1)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.x        (sample_ch.sample),
				.up_val   (up_val),
				.up_age   (up_age),
				.up_valid (up_valid),
				.up_gt    (up_gt),
				.dn_val   (dn_val),
				.dn_age   (dn_age),
				.dn_valid (dn_valid),
				.dn_ins   (dn_ins),
				.sh_in    (sh_in),
				.sh_out   (sh_w[gi]),
				.val      (val_w[gi]),
				.age      (age_w[gi]),
				.valid    (valid_w[gi]),
				.gt       (gt_w[gi]),
				.rm       (rm_w[gi]),
				.cval     (cval_w[gi]),
				.cage     (cage_w[gi]),
				.cvalid   (cvalid_w[gi]),
				.cins     (cins_w[gi]),
				.nxt_val  (nxt_w[gi])
			);
		end
	endgenerate

	// Fill count; a row end empties the window after the sample is used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.step) begin
			count_q <= ctl.flush ? '0 : count_nxt;
		end
	end

	// Output register: the center of the updated window, captured before a flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.step) begin
			out_valid_q <= emit;
		end else if (median_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && emit) begin
			median_q <= nxt_w[MID];
		end
	end

	assign median_ch.valid  = out_valid_q;
	assign median_ch.median = median_q;

	// Occupied cells are exactly the lowest count_q slots.
	a_valid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid_w == N'((64'd1 << count_q) - 64'd1))
		else $error("cell occupancy disagrees with fill count");

	// A full window holds exactly one entry due to leave.
	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == FULL) |-> $onehot(rm_w))
		else $error("full window without a single oldest entry");

	// No median for a sample that leaves the window short.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && (count_nxt != FULL)) |=> !median_ch.valid)
		else $error("median emitted before the window filled");

	// Occupied neighbors stay in ascending order.
	generate
		for (gi = 0; gi < N - 1; gi++) begin : g_chk
			a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				valid_w[gi+1] |-> (val_w[gi] <= val_w[gi+1]))
				else $error("sorted window out of order");
		end
	endgenerate

endmodule : sliding_median_filter_unit

FILE: sim/tb_top.sv
// tb_top: self-checking bench for sliding_median_filter_unit (7-tap running median).
// Depends on smf_if.sv (smf_in_if / smf_out_if) and the RTL top; drives rows of samples,
// predicts each window median and checks the median stream beat by beat.
`timescale 1ns / 1ps

module tb_top;

	localparam int TAPS      = 7;
	localparam int BITS      = 12;
	localparam int MAX_VAL   = (1 << BITS) - 1;
	localparam int WATCHDOG  = 2000;  // cycles with no beat on either side
	localparam int TAIL_WAIT = 16;    // median is registered, shows in the cycle after its sample
	localparam int RAND_BEATS = 800;
	localparam int MAX_SHOWN = 10;

	// value shapes for generated rows
	typedef enum int {
		VAL_FULL,
		VAL_CLUSTER,
		VAL_EXTREME,
		VAL_RAMP
	} val_shape_t;

	typedef struct {
		logic [BITS-1:0] sample;
		logic            last_in_row;
		bit              drain_first;  // hold this beat until all medians are back
	} sample_beat_t;

	logic clk;
	logic arst_n;

	smf_in_if  #(.SAMPLE_BITS(BITS)) sample_ch ();
	smf_out_if #(.SAMPLE_BITS(BITS)) median_ch ();

	sliding_median_filter_unit #(
		.WINDOW_TAPS(TAPS),
		.SAMPLE_BITS(BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_ch(sample_ch),
		.median_ch(median_ch)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: its own copy of the window, oldest entry first.
	// ------------------------------------------------------------------
	logic [BITS-1:0] row_window [TAPS];
	int              window_fill;
	logic [BITS-1:0] median_expect_q [$];

	function automatic logic [BITS-1:0] window_median();
		logic [BITS-1:0] sorted [TAPS];
		logic [BITS-1:0] v;
		int              k;
		for (int i = 0; i < TAPS; i++) begin
			v = row_window[i];
			k = i;
			while (k > 0 && v < sorted[k-1]) begin
				sorted[k] = sorted[k-1];
				k--;
			end
			sorted[k] = v;
		end
		// even tap counts take the upper middle value
		return sorted[TAPS/2];
	endfunction

	// Shift one sample in; a full window yields a median. Row end clears afterwards.
	task automatic predict_median(input logic [BITS-1:0] s, input logic row_end);
		for (int i = 0; i + 1 < TAPS; i++)
			row_window[i] = row_window[i+1];
		row_window[TAPS-1] = s;
		if (window_fill < TAPS)
			window_fill++;
		if (window_fill >= TAPS)
			median_expect_q.insert(median_expect_q.size(), window_median());
		if (row_end) begin
			foreach (row_window[i])
				row_window[i] = '0;
			window_fill = 0;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus store
	// ------------------------------------------------------------------
	sample_beat_t pending_q [$];

	task automatic add_beat(input int s, input bit row_end, input bit drain = 0);
		sample_beat_t b;
		b.sample      = s[BITS-1:0];
		b.last_in_row = row_end;
		b.drain_first = drain;
		pending_q.insert(pending_q.size(), b);
	endtask

	function automatic int draw_value(input val_shape_t shape, input int base, input int pos);
		case (shape)
			VAL_CLUSTER: begin
				// narrow spread so the window carries many equal values
				return (base + $urandom_range(0, 3)) & MAX_VAL;
			end
			VAL_EXTREME: begin
				return $urandom_range(0, 1) ? MAX_VAL : 0;
			end
			VAL_RAMP: begin
				return (base + pos * 37) & MAX_VAL;
			end
			default: begin
				return $urandom_range(0, MAX_VAL);
			end
		endcase
	endfunction

	task automatic add_row(input int len, input bit drain);
		val_shape_t shape;
		int         base;
		shape = val_shape_t'($urandom_range(0, 3));
		base  = $urandom_range(0, MAX_VAL);
		for (int p = 0; p < len; p++)
			add_beat(draw_value(shape, base, p), p == len - 1, drain && p == 0);
	endtask

	// ------------------------------------------------------------------
	// Driver: sender in bursts with random gaps, inputs change on the falling edge.
	// ------------------------------------------------------------------
	int           beats_sent;
	int           beats_taken;
	int           burst_left;
	int           gap_left;
	sample_beat_t next_beat;

	always @(negedge clk) begin
		if (arst_n) begin
			// a beat still on the bus and not yet taken stays put
			if (!(sample_ch.valid && beats_taken != beats_sent)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					sample_ch.valid <= 1'b0;
				end else if (pending_q.size() == 0 ||
						(pending_q[0].drain_first && median_expect_q.size() != 0)) begin
					sample_ch.valid <= 1'b0;
				end else begin
					next_beat = pending_q.pop_front();
					sample_ch.valid       <= 1'b1;
					sample_ch.sample      <= next_beat.sample;
					sample_ch.last_in_row <= next_beat.last_in_row;
					beats_sent++;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						// most bursts run back to back, some leave a hole
						gap_left <= ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: ready follows a rotating 16-bit pattern, redrawn now and then.
	// Every pattern keeps at least one ready bit, so no stall lasts a whole rotation.
	// ------------------------------------------------------------------
	logic [15:0] stall_pattern;
	int          pattern_age;

	always @(negedge clk) begin
		median_ch.ready <= stall_pattern[0];
		if (pattern_age == 63) begin
			pattern_age <= 0;
			case ($urandom_range(0, 3))
				0:       stall_pattern <= 16'hffff;
				1:       stall_pattern <= 16'($urandom()) | 16'h0001;
				2:       stall_pattern <= 16'($urandom()) | 16'($urandom()) | 16'h0001;
				default: stall_pattern <= (16'($urandom()) & 16'($urandom())) | 16'h0001;
			endcase
		end else begin
			pattern_age   <= pattern_age + 1;
			stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
		end
	end

	// ------------------------------------------------------------------
	// Monitor and scoreboard, sampled on the rising edge. Output is checked
	// before the input side: a median never comes out in its own sample's cycle.
	// ------------------------------------------------------------------
	int              fault_count;
	int              idle_cycles;
	bit              progress;
	logic [BITS-1:0] want;

	always @(posedge clk) begin
		if (arst_n) begin
			progress = 0;
			if (median_ch.valid && median_ch.ready) begin
				progress = 1;
				if (median_expect_q.size() == 0) begin
					fault_count++;
					if (fault_count <= MAX_SHOWN)
						$display("%0t: median beat 0x%03h with none expected",
							$realtime, median_ch.median);
				end else begin
					want = median_expect_q.pop_front();
					if (median_ch.median !== want) begin
						fault_count++;
						if (fault_count <= MAX_SHOWN)
							$display("%0t: median mismatch, expected 0x%03h got 0x%03h",
								$realtime, want, median_ch.median);
					end
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				progress = 1;
				predict_median(sample_ch.sample, sample_ch.last_in_row);
				beats_taken++;
			end
			idle_cycles = progress ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("[sliding_median_filter_unit] ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: directed rows, then random rows, then drain and verdict.
	// ------------------------------------------------------------------
	int random_beats;
	int row_len;

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		sample_ch.valid       = 1'b0;
		sample_ch.sample      = '0;
		sample_ch.last_in_row = 1'b0;
		stall_pattern         = 16'hffff;
		pattern_age           = 0;
		burst_left            = 1;
		gap_left              = 0;
		beats_sent            = 0;
		beats_taken           = 0;
		fault_count           = 0;
		idle_cycles           = 0;
		window_fill           = 0;
		foreach (row_window[i])
			row_window[i] = '0;

		// Directed: alternating extremes fill the window, then it slides and saturates.
		for (int i = 0; i < 10; i++)
			add_beat((i % 2) ? MAX_VAL : 0, i == 9);
		// Short row: never fills, no median at all.
		add_beat(MAX_VAL, 0);
		add_beat(1, 0);
		add_beat(2048, 1);
		// Row ending exactly when the window first fills; descending values.
		for (int i = 0; i < TAPS; i++)
			add_beat(MAX_VAL - i * 600, i == TAPS - 1);
		// One-beat row, then a fresh row waits for all medians first.
		add_beat(MAX_VAL, 1);

		// Random rows: mostly long enough to produce medians, some too short.
		random_beats = 0;
		while (random_beats < RAND_BEATS) begin
			row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, TAPS - 1)
				: $urandom_range(TAPS, 60);
			// first random row and the odd later one start only once idle
			add_row(row_len, random_beats == 0 || $urandom_range(0, 19) == 0);
			random_beats += row_len;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// the watchdog bounds every wait below
		while (pending_q.size() != 0 || beats_taken != beats_sent ||
				median_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (fault_count == 0 && median_expect_q.size() == 0) begin
			$display("[sliding_median_filter_unit] OK");
		end else begin
			$display("[sliding_median_filter_unit] ERROR");
		end
		$finish;
	end

endmodule : tb_top
